>>> rtl/csr_pkg.sv
// Shared types, constants and rounding helper for the Chebyshev series
// reconstruction block. No dependencies.
`timescale 1ns / 1ps
package csr_pkg;

    // accumulator width for the series sum
    localparam int SUMW = 48;

    // pi in Q.29
    localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // control word to the iterative root / divide unit
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } iter_ctrl_t;

    // v / 2^s rounded half away from zero
    function automatic logic signed [64:0] rnd_shift(input logic signed [64:0] v,
                                                     input int s);
        logic        neg;
        logic [65:0] mag;
        logic [65:0] half;
        begin
            neg  = v[64];
            mag  = neg ? (66'd0 - {v[64], v}) : {1'b0, v};
            half = 66'd1 << (s - 1);
            mag  = (mag + half) >> s;
            rnd_shift = neg ? (65'sd0 - $signed(mag[64:0])) : $signed(mag[64:0]);
        end
    endfunction

endpackage

>>> rtl/csr_req_if.sv
// Request channel interface: valid/ready plus the input word fields.
// No dependencies.
`timescale 1ns / 1ps
interface csr_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [7:0]         index;
    logic [17:0]        kernel_coef;
    logic signed [23:0] moment;
    logic signed [15:0] point;

    modport source (output valid, req_type, index, kernel_coef, moment, point,
                    input ready);
    modport sink   (input valid, req_type, index, kernel_coef, moment, point,
                    output ready);
endinterface

>>> rtl/csr_rsp_if.sv
// Result channel interface: valid/ready plus the result word fields.
// No dependencies.
`timescale 1ns / 1ps
interface csr_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] density;
    logic               out_of_domain;

    modport source (output valid, density, out_of_domain, input ready);
    modport sink   (input valid, density, out_of_domain, output ready);
endinterface

>>> rtl/csr_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nothing but the clock.
`timescale 1ns / 1ps
module csr_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [31:0] b,
    output logic signed [64:0] p_reg
);

    // one multiply per cycle, product registered at full width
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

>>> rtl/csr_iter.sv
// Bit-serial unit: 32-step integer square root or restoring divide,
// sharing one compare/subtract. Depends on csr_pkg.
`timescale 1ns / 1ps
module csr_iter
    import csr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iter_ctrl_t  ctrl,
    input  logic [32:0] rem_init,
    input  logic [63:0] src_init,
    input  logic [30:0] divisor,
    output logic        done,
    output logic [31:0] result
);

    logic        busy_reg;
    logic        done_reg;
    logic        sqrt_reg;
    logic [4:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [31:0] root_reg;
    logic [63:0] src_reg;

    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;
    logic [34:0] diff;

    // shift in one digit and try the subtract
    always_comb
    begin
        if (sqrt_reg)
        begin
            rem_sh = {rem_reg, src_reg[63:62]};
            trial  = {1'b0, root_reg, 2'b01};
        end
        else
        begin
            rem_sh = {1'b0, rem_reg, src_reg[63]};
            trial  = {4'b0, divisor};
        end
        ge   = rem_sh >= trial;
        diff = rem_sh - trial;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            sqrt_reg <= ctrl.is_sqrt;
            rem_reg  <= rem_init;
            src_reg  <= src_init;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[32:0] : rem_sh[32:0];
            root_reg <= {root_reg[30:0], ge};
            src_reg  <= sqrt_reg ? {src_reg[61:0], 2'b00} : {src_reg[62:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = root_reg;

endmodule

>>> rtl/chebyshev_series_reconstruct_unit.sv
// Top level of the Chebyshev series reconstruction block: coefficient store,
// sequencer, shared multiplier and bit-serial root/divide unit.
// Depends on csr_pkg, csr_req_if, csr_rsp_if, csr_mul, csr_iter.
`timescale 1ns / 1ps
// A load word passes through a multiply and a store write. An evaluate word
// walks the coefficient store term by term in the series loop, through the
// one shared multiplier (coefficient times T_n, then 2x times T_n); the
// square root and the final divide each hold the sequencer in the bit-serial
// unit (32 steps plus the done flag), and x*x, the pi multiply and the setup
// steps come before the loop. A point at minus one returns a flagged zero
// on the cycle after it is taken. The block takes one word at a time; the
// result register holds until taken. Store entries must be loaded before
// they are summed.
module chebyshev_series_reconstruct_unit
    import csr_pkg::*;
#(
    parameter int MAX_ORDER = 256
)(
    input  logic       clk,
    input  logic       rst_n,
    csr_req_if.sink    req_ch,
    csr_rsp_if.source  rsp_ch,
    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata
);

    localparam int AW = $clog2(MAX_ORDER);
    localparam int CW = $clog2(MAX_ORDER + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LMUL = 4'd1;
    localparam logic [3:0] ST_LWR  = 4'd2;
    localparam logic [3:0] ST_XSQ  = 4'd3;
    localparam logic [3:0] ST_SQS  = 4'd4;
    localparam logic [3:0] ST_SQW  = 4'd5;
    localparam logic [3:0] ST_PIM  = 4'd6;
    localparam logic [3:0] ST_DENS = 4'd7;
    localparam logic [3:0] ST_L1   = 4'd8;
    localparam logic [3:0] ST_L2   = 4'd9;
    localparam logic [3:0] ST_L3   = 4'd10;
    localparam logic [3:0] ST_DIVS = 4'd11;
    localparam logic [3:0] ST_DIVW = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    logic [3:0]  state_reg, state_next;
    logic [8:0]  order_reg;

    // latched request word
    logic [7:0]         index_reg;
    logic [17:0]        kcoef_reg;
    logic signed [23:0] moment_reg;
    logic signed [15:0] x_reg;

    // coefficient store
    logic [31:0] mem [MAX_ORDER];
    logic [31:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic          wr_en;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;

    // evaluation state
    logic [CW-1:0]       n_reg;
    logic [CW-1:0]       n_plus1;
    logic [CW-1:0]       ord;
    logic signed [31:0]  c0_reg;
    logic signed [31:0]  tp_reg;
    logic signed [31:0]  tc_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic [30:0]         den_reg;
    logic                neg_reg;
    logic                ovf_reg;
    logic signed [31:0]  density_reg;
    logic                ood_reg;

    // shared units
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] prod;
    iter_ctrl_t         iter_ctrl;
    logic [32:0]        iter_rem;
    logic [63:0]        iter_src;
    logic               iter_done;
    logic [31:0]        iter_res;

    // derived values
    logic [15:0]         cfg16;
    logic [15:0]         max16;
    logic [15:0]         ord16;
    logic [15:0]         idx16;
    logic signed [64:0]  rnd17;
    logic signed [64:0]  rnd15;
    logic signed [64:0]  rnd30;
    logic signed [34:0]  tn_raw;
    logic signed [31:0]  tn;
    logic [64:0]         den_tmp;
    logic signed [SUMW+1:0] s_val;
    logic [SUMW+1:0]     s_mag;
    logic [72:0]         num;
    logic [31:0]         qsat;

    assign req_ch.ready = (state_reg == ST_IDLE);
    wire req_acc = req_ch.valid && req_ch.ready;

    // effective order: zero acts as one, clamp to store depth
    always_comb
    begin
        cfg16 = {7'b0, order_reg};
        max16 = 16'(MAX_ORDER);
        if (cfg16 == 16'd0)
            ord16 = 16'd1;
        else if (cfg16 > max16)
            ord16 = max16;
        else
            ord16 = cfg16;
        ord     = ord16[CW-1:0];
        n_plus1 = n_reg + 1'b1;
        idx16   = {8'b0, index_reg};
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= 9'd256;
        else if (cfg_we)
            order_reg <= cfg_wdata;
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_LMUL:
            begin
                mul_a = $signed({15'b0, kcoef_reg});
                mul_b = 32'(moment_reg);
            end
            ST_XSQ:
            begin
                mul_a = 33'(x_reg);
                mul_b = 32'(x_reg);
            end
            ST_PIM:
            begin
                mul_a = $signed({1'b0, iter_res});
                mul_b = PI_Q29;
            end
            ST_L1:
            begin
                mul_a = 33'($signed(rdata_reg));
                mul_b = tc_reg;
            end
            ST_L2:
            begin
                mul_a = 33'($signed({x_reg, 1'b0}));
                mul_b = tc_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    csr_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod)
    );

    // rounding, recurrence and divide setup
    always_comb
    begin
        rnd17   = rnd_shift(prod, 17);
        rnd15   = rnd_shift(prod, 15);
        rnd30   = rnd_shift(prod, 30);
        tn_raw  = rnd15[34:0] - 35'(tp_reg);
        if (tn_raw > 35'(ONE_Q30))
            tn = ONE_Q30;
        else if (tn_raw < -35'(ONE_Q30))
            tn = -ONE_Q30;
        else
            tn = tn_raw[31:0];
        den_tmp = prod + 65'd536870912;
        s_val   = (SUMW+2)'(c0_reg) + ((SUMW+2)'(sum_reg) <<< 1);
        s_mag   = s_val[SUMW+1] ? ((SUMW+2)'(0) - s_val) : s_val;
        num     = ((73)'(s_mag) << 23) + 73'(den_reg >> 1);
    end

    // iterative unit hookup
    always_comb
    begin
        iter_ctrl.start   = (state_reg == ST_SQS) || (state_reg == ST_DIVS);
        iter_ctrl.is_sqrt = (state_reg == ST_SQS);
        if (state_reg == ST_SQS)
        begin
            iter_rem = '0;
            iter_src = {3'b0, 31'(ONE_Q30 - prod[31:0]), 30'b0};
        end
        else
        begin
            iter_rem = {2'b0, num[62:32]};
            iter_src = {num[31:0], 32'b0};
        end
    end

    csr_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (iter_ctrl),
        .rem_init (iter_rem),
        .src_init (iter_src),
        .divisor  (den_reg),
        .done     (iter_done),
        .result   (iter_res)
    );

    // store read / write
    assign raddr = (state_reg == ST_L3) ? n_plus1[AW-1:0] : n_reg[AW-1:0];
    assign wr_en = (state_reg == ST_LWR) && (idx16 < 16'(MAX_ORDER));
    assign waddr = idx16[AW-1:0];
    assign wdata = rnd17[31:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    if (req_ch.req_type == REQ_LOAD)
                        state_next = ST_LMUL;
                    else if (req_ch.point == 16'sh8000)
                        state_next = ST_OUT;
                    else
                        state_next = ST_XSQ;
                end
            end
            ST_LMUL: state_next = ST_LWR;
            ST_LWR:  state_next = ST_IDLE;
            ST_XSQ:  state_next = ST_SQS;
            ST_SQS:  state_next = ST_SQW;
            ST_SQW:  state_next = iter_done ? ST_PIM : ST_SQW;
            ST_PIM:  state_next = ST_DENS;
            ST_DENS: state_next = (ord == CW'(1)) ? ST_DIVS : ST_L1;
            ST_L1:   state_next = ST_L2;
            ST_L2:   state_next = ST_L3;
            ST_L3:   state_next = (n_plus1 == ord) ? ST_DIVS : ST_L1;
            ST_DIVS: state_next = ST_DIVW;
            ST_DIVW: state_next = iter_done ? ST_OUT : ST_DIVW;
            ST_OUT:  state_next = rsp_ch.ready ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // final saturation
    always_comb
    begin
        if (neg_reg)
            qsat = (ovf_reg || iter_res > 32'h8000_0000) ? 32'h8000_0000 : iter_res;
        else
            qsat = (ovf_reg || iter_res > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : iter_res;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    index_reg   <= req_ch.index;
                    kcoef_reg   <= req_ch.kernel_coef;
                    moment_reg  <= req_ch.moment;
                    x_reg       <= req_ch.point;
                    n_reg       <= '0;
                    density_reg <= '0;
                    ood_reg     <= (req_ch.point == 16'sh8000);
                end
            end
            ST_SQS:
            begin
                c0_reg <= $signed(rdata_reg);
                n_reg  <= CW'(1);
            end
            ST_DENS:
            begin
                den_reg <= den_tmp[60:30];
                tp_reg  <= ONE_Q30;
                tc_reg  <= 32'($signed({x_reg, 15'b0}));
                sum_reg <= '0;
            end
            ST_L2:
            begin
                sum_reg <= sum_reg + rnd30[SUMW-1:0];
            end
            ST_L3:
            begin
                tp_reg <= tc_reg;
                tc_reg <= tn;
                n_reg  <= n_plus1;
            end
            ST_DIVS:
            begin
                neg_reg <= s_val[SUMW+1];
                ovf_reg <= num[72:32] >= 41'(den_reg);
            end
            ST_DIVW:
            begin
                if (iter_done)
                    density_reg <= neg_reg ? (32'sd0 - $signed(qsat)) : $signed(qsat);
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_ch.valid         = (state_reg == ST_OUT);
    assign rsp_ch.density       = density_reg;
    assign rsp_ch.out_of_domain = ood_reg;

endmodule

>>> rtl/csr_checker.sv
// Port-level checks for the Chebyshev series reconstruction block, bound
// to the top level. Depends on chebyshev_series_reconstruct_unit.
`timescale 1ns / 1ps
module csr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               req_type,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic signed [31:0] density,
    input logic               out_of_domain
);

    // a pending result blocks new words
    a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request ready while a result is pending");

    // an evaluate word drops ready at once
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_type) |=> !req_ready)
        else $error("ready held after evaluate word");

    // flagged points give zero density
    a_ood_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && out_of_domain) |-> (density == 32'sd0))
        else $error("out-of-domain result with nonzero density");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(density)))
        else $error("result dropped or changed while stalled");

endmodule

bind chebyshev_series_reconstruct_unit csr_checker u_csr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_ch.valid),
    .req_ready     (req_ch.ready),
    .req_type      (req_ch.req_type),
    .rsp_valid     (rsp_ch.valid),
    .rsp_ready     (rsp_ch.ready),
    .density       (rsp_ch.density),
    .out_of_domain (rsp_ch.out_of_domain)
);
